// File: hdl/pressure_temperature_compensation_macros.svh
// assertion macros for the compensation block
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// implication checked on every clock edge outside reset
`define PTC_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("ptc check failed");

// next-cycle implication checked on every clock edge outside reset
`define PTC_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("ptc check failed");

// next-cycle implication that also holds across reset
`define PTC_ASSERT_RST(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("ptc check failed");

`endif

// File: hdl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

  localparam int DIV_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERSAMPLING = 3'd0,
    REG_COEF_AC_SIGNED = 3'd1,
    REG_COEF_AC_UNSIGNED = 3'd2,
    REG_COEF_B_PAIR = 3'd3,
    REG_COEF_M_PAIR = 3'd4
  } cfg_reg_t;

  localparam logic [31:0] C_4000 = 32'd4000;
  localparam logic [31:0] C_32768 = 32'd32768;
  localparam logic [31:0] C_50000 = 32'd50000;
  localparam logic [31:0] C_3038 = 32'd3038;
  localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791 = 32'd3791;
  // ceil(2^35 / 10): (n * this) >> 35 is n / 10 for any 32-bit n
  localparam logic [31:0] C_RECIP_TEN = 32'hCCCC_CCCD;

  // temperature division side data
  typedef struct packed {
    logic [31:0] x1;
    logic [18:0] up;
    logic        err;
    logic        neg;
  } side1_t;

  // pressure division side data
  typedef struct packed {
    logic [31:0] b5;
    logic        b7_msb;
    logic        err;
  } side2_t;

  // divide-by-ten side data
  typedef struct packed {
    logic [31:0] b5;
    logic [31:0] p;
    logic        err;
  } side3_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
    logic signed [31:0] s;
    s = $signed(v);
    return $unsigned(s >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ptc_div_cell.sv
`default_nettype none
module ptc_div_cell import ptc_pkg::*; #(
  parameter int W = DIV_W,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_i,
  input  wire logic [W-1:0]  rem_i,
  input  wire logic [W-1:0]  dvd_i,
  input  wire logic [W-1:0]  dvs_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [W-1:0]       rem_o,
  output logic [W-1:0]       dvd_o,
  output logic [W-1:0]       dvs_o,
  output logic [SW-1:0]      side_o
);

  logic [W:0] rem_sh;
  logic [W:0] diff;
  logic       fits;

  // one restoring step: shift in the next dividend bit, try a subtract
  always_comb begin
    rem_sh = {rem_i, dvd_i[W-1]};
    diff   = rem_sh - {1'b0, dvs_i};
    fits   = !diff[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= fits ? diff[W-1:0] : rem_sh[W-1:0];
      dvd_o  <= {dvd_i[W-2:0], fits};
      dvs_o  <= dvs_i;
      side_o <= side_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ptc_div_chain.sv
`default_nettype none
module ptc_div_chain import ptc_pkg::*; #(
  parameter int W = DIV_W,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_i,
  input  wire logic [W-1:0]  dvd_i,
  input  wire logic [W-1:0]  dvs_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [W-1:0]       quo_o,
  output logic [SW-1:0]      side_o
);

  logic          vld  [W+1];
  logic [W-1:0]  rem  [W+1];
  logic [W-1:0]  dvd  [W+1];
  logic [W-1:0]  dvs  [W+1];
  logic [SW-1:0] side [W+1];

  assign vld[0]  = vld_i;
  assign rem[0]  = '0;
  assign dvd[0]  = dvd_i;
  assign dvs[0]  = dvs_i;
  assign side[0] = side_i;

  for (genvar i = 0; i < W; i++) begin : g_cell
    ptc_div_cell #(.W(W), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld[i]),
      .rem_i  (rem[i]),
      .dvd_i  (dvd[i]),
      .dvs_i  (dvs[i]),
      .side_i (side[i]),
      .vld_o  (vld[i+1]),
      .rem_o  (rem[i+1]),
      .dvd_o  (dvd[i+1]),
      .dvs_o  (dvs[i+1]),
      .side_o (side[i+1])
    );
  end

  assign vld_o  = vld[W];
  assign quo_o  = dvd[W];
  assign side_o = side[W];

endmodule
`default_nettype wire

// File: hdl/pressure_temperature_compensation.sv
// throughput: one request per cycle while no result waits under out_stall,
//   set by the two 32-cell divider chains that each retire one quotient bit
//   per cell per cycle; the final divide by ten is a registered reciprocal
//   multiply
// reset: synchronous active-low rst_n clears all valid bits, oversampling to 3
//   and the coefficients to zero
`default_nettype none
module pressure_temperature_compensation import ptc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           in_raw_temperature,
  input  wire logic [18:0]           in_raw_pressure,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         out_temperature_tenths,
  output logic signed [31:0]         out_pressure_pascal,
  output logic signed [15:0]         out_pressure_tens,
  output logic                       out_divide_error,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------- configuration registers ----------------
  logic [1:0]  oss_r;
  logic [47:0] ac_s_r;
  logic [47:0] ac_u_r;
  logic [31:0] b_pair_r;
  logic [31:0] m_pair_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r    <= 2'd3;
      ac_s_r   <= '0;
      ac_u_r   <= '0;
      b_pair_r <= '0;
      m_pair_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OVERSAMPLING:     oss_r    <= cfg_data[1:0];
        REG_COEF_AC_SIGNED:   ac_s_r   <= cfg_data[47:0];
        REG_COEF_AC_UNSIGNED: ac_u_r   <= cfg_data[47:0];
        REG_COEF_B_PAIR:      b_pair_r <= cfg_data[31:0];
        REG_COEF_M_PAIR:      m_pair_r <= cfg_data[31:0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // unpacked calibration words
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(ac_s_r[15:0]);
  assign ac2 = sx16(ac_s_r[31:16]);
  assign ac3 = sx16(ac_s_r[47:32]);
  assign ac4 = {16'd0, ac_u_r[15:0]};
  assign ac5 = {16'd0, ac_u_r[31:16]};
  assign ac6 = {16'd0, ac_u_r[47:32]};
  assign b1  = sx16(b_pair_r[15:0]);
  assign b2  = sx16(b_pair_r[31:16]);
  assign mc  = sx16(m_pair_r[15:0]);
  assign md  = sx16(m_pair_r[31:16]);

  // ---------------- pipeline control ----------------
  // the whole pipe moves as one; it freezes only while a result waits
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage a: first temperature product
  logic        a_vld_r;
  logic [31:0] a_m1_r;
  logic [18:0] a_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_m1_r <= ({16'd0, in_raw_temperature} - ac6) * ac5;
      a_up_r <= in_raw_pressure;
    end
  end

  // stage b: temperature divisor and magnitudes for the signed divide
  logic        b_vld_r;
  side1_t      b_side_r;
  logic [31:0] b_dvd_r, b_dvs_r;
  logic [31:0] b_x1, b_den, b_num;
  always_comb begin
    b_x1  = asr32(a_m1_r, 15);
    b_den = b_x1 + md;
    b_num = mc << 11;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_dvd_r      <= abs32(b_num);
      b_dvs_r      <= abs32(b_den);
      b_side_r.x1  <= b_x1;
      b_side_r.up  <= a_up_r;
      b_side_r.err <= (b_den == 32'd0);
      b_side_r.neg <= b_num[31] ^ b_den[31];
    end
  end

  // divider chain 1: x2 = (mc << 11) / (x1 + md)
  logic        d1_vld;
  logic [31:0] d1_quo;
  side1_t      d1_side;
  ptc_div_chain #(.W(DIV_W), .SW($bits(side1_t))) u_div_temp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (b_vld_r),
    .dvd_i  (b_dvd_r),
    .dvs_i  (b_dvs_r),
    .side_i (b_side_r),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  // stage c: b5 and b6
  logic        c_vld_r, c_err_r;
  logic [31:0] c_b5_r, c_b6_r;
  logic [18:0] c_up_r;
  logic [31:0] c_x2, c_b5;
  always_comb begin
    c_x2 = d1_side.neg ? (32'd0 - d1_quo) : d1_quo;
    c_b5 = d1_side.x1 + c_x2;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= d1_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_b5_r  <= c_b5;
      c_b6_r  <= c_b5 - C_4000;
      c_up_r  <= d1_side.up;
      c_err_r <= d1_side.err;
    end
  end

  // stage d: products with b6
  logic        d_vld_r, d_err_r;
  logic [31:0] d_sq_r, d_ac2_r, d_ac3_r, d_b5_r;
  logic [18:0] d_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= c_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_sq_r  <= c_b6_r * c_b6_r;
      d_ac2_r <= ac2 * c_b6_r;
      d_ac3_r <= ac3 * c_b6_r;
      d_b5_r  <= c_b5_r;
      d_up_r  <= c_up_r;
      d_err_r <= c_err_r;
    end
  end

  // stage e: scale the products
  logic        e_vld_r, e_err_r;
  logic [31:0] e_sq_r, e_x2a_r, e_x1c_r, e_b5_r;
  logic [18:0] e_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else if (en) e_vld_r <= d_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_sq_r  <= asr32(d_sq_r, 12);
      e_x2a_r <= asr32(d_ac2_r, 11);
      e_x1c_r <= asr32(d_ac3_r, 13);
      e_b5_r  <= d_b5_r;
      e_up_r  <= d_up_r;
      e_err_r <= d_err_r;
    end
  end

  // stage f: products with the squared term
  logic        f_vld_r, f_err_r;
  logic [31:0] f_mb2_r, f_mb1_r, f_x2a_r, f_x1c_r, f_b5_r;
  logic [18:0] f_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= e_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_mb2_r <= b2 * e_sq_r;
      f_mb1_r <= b1 * e_sq_r;
      f_x2a_r <= e_x2a_r;
      f_x1c_r <= e_x1c_r;
      f_b5_r  <= e_b5_r;
      f_up_r  <= e_up_r;
      f_err_r <= e_err_r;
    end
  end

  // stage g: b3 and the b4 multiplicand
  logic        g_vld_r, g_err_r;
  logic [31:0] g_b3_r, g_t_r, g_b5_r;
  logic [18:0] g_up_r;
  logic [31:0] g_x3, g_b3, g_x3b;
  always_comb begin
    g_x3  = asr32(f_mb2_r, 11) + f_x2a_r;
    g_b3  = asr32((((ac1 << 2) + g_x3) << oss_r) + 32'd2, 2);
    g_x3b = asr32(f_x1c_r + asr32(f_mb1_r, 16) + 32'd2, 2);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else if (en) g_vld_r <= f_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      g_b3_r  <= g_b3;
      g_t_r   <= g_x3b + C_32768;
      g_b5_r  <= f_b5_r;
      g_up_r  <= f_up_r;
      g_err_r <= f_err_r;
    end
  end

  // stage h: b4 product and up - b3
  logic        h_vld_r, h_err_r;
  logic [31:0] h_mb4_r, h_d_r, h_b5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else if (en) h_vld_r <= g_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      h_mb4_r <= ac4 * g_t_r;
      h_d_r   <= {13'd0, g_up_r} - g_b3_r;
      h_b5_r  <= g_b5_r;
      h_err_r <= g_err_r;
    end
  end

  // stage i: b4 and b7
  logic        i_vld_r, i_err_r;
  logic [31:0] i_b4_r, i_b7_r, i_b5_r;
  logic [31:0] i_b4;
  assign i_b4 = h_mb4_r >> 15;
  always_ff @(posedge clk) begin
    if (!rst_n) i_vld_r <= 1'b0;
    else if (en) i_vld_r <= h_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      i_b4_r  <= i_b4;
      i_b7_r  <= h_d_r * (C_50000 >> oss_r);
      i_b5_r  <= h_b5_r;
      i_err_r <= h_err_r | (i_b4 == 32'd0);
    end
  end

  // divider chain 2: unsigned pressure divide, doubling before or after
  side2_t      i_side;
  logic [31:0] i_dvd;
  assign i_side.b5     = i_b5_r;
  assign i_side.b7_msb = i_b7_r[31];
  assign i_side.err    = i_err_r;
  assign i_dvd         = i_b7_r[31] ? i_b7_r : (i_b7_r << 1);

  logic        d2_vld;
  logic [31:0] d2_quo;
  side2_t      d2_side;
  ptc_div_chain #(.W(DIV_W), .SW($bits(side2_t))) u_div_pres (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (i_vld_r),
    .dvd_i  (i_dvd),
    .dvs_i  (i_b4_r),
    .side_i (i_side),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side)
  );

  // stage j: raw pressure p
  logic        j_vld_r, j_err_r;
  logic [31:0] j_p_r, j_b5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) j_vld_r <= 1'b0;
    else if (en) j_vld_r <= d2_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      j_p_r   <= d2_side.b7_msb ? (d2_quo << 1) : d2_quo;
      j_b5_r  <= d2_side.b5;
      j_err_r <= d2_side.err;
    end
  end

  // stage k: correction products
  logic        k_vld_r, k_err_r;
  logic [31:0] k_qq_r, k_mp_r, k_p_r, k_b5_r;
  logic [31:0] k_q;
  assign k_q = asr32(j_p_r, 8);
  always_ff @(posedge clk) begin
    if (!rst_n) k_vld_r <= 1'b0;
    else if (en) k_vld_r <= j_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k_qq_r  <= k_q * k_q;
      k_mp_r  <= C_M7357 * j_p_r;
      k_p_r   <= j_p_r;
      k_b5_r  <= j_b5_r;
      k_err_r <= j_err_r;
    end
  end

  // stage l: scale the square term
  logic        l_vld_r, l_err_r;
  logic [31:0] l_m3_r, l_x2_r, l_p_r, l_b5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) l_vld_r <= 1'b0;
    else if (en) l_vld_r <= k_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      l_m3_r  <= k_qq_r * C_3038;
      l_x2_r  <= asr32(k_mp_r, 16);
      l_p_r   <= k_p_r;
      l_b5_r  <= k_b5_r;
      l_err_r <= k_err_r;
    end
  end

  // stage m: corrected pressure
  logic        m_vld_r;
  side3_t      m_side_r;
  logic [31:0] m_p;
  assign m_p = l_p_r + asr32(asr32(l_m3_r, 16) + l_x2_r + C_3791, 4);
  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else if (en) m_vld_r <= l_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r.p   <= m_p;
      m_side_r.b5  <= l_b5_r;
      m_side_r.err <= l_err_r;
    end
  end

  // stage n: pressure magnitude over ten, multiply by the reciprocal and
  // keep the bits above 2^35
  logic        n_vld_r;
  side3_t      n_side_r;
  logic [31:0] n_quo_r;
  logic [63:0] n_prod;
  assign n_prod = {32'd0, abs32(m_side_r.p)} * {32'd0, C_RECIP_TEN};
  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else if (en) n_vld_r <= m_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n_quo_r  <= {3'd0, n_prod[63:35]};
      n_side_r <= m_side_r;
    end
  end

  // output register; a divide error forces every result to zero
  logic [31:0] o_tens, o_temp;
  always_comb begin
    o_tens = n_side_r.p[31] ? (32'd0 - n_quo_r) : n_quo_r;
    o_temp = asr32(n_side_r.b5 + 32'd8, 4);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= n_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_divide_error       <= n_side_r.err;
      out_temperature_tenths <= n_side_r.err ? 16'sd0 : $signed(o_temp[15:0]);
      out_pressure_pascal    <= n_side_r.err ? 32'sd0 : $signed(n_side_r.p);
      out_pressure_tens      <= n_side_r.err ? 16'sd0 : $signed(o_tens[15:0]);
    end
  end

endmodule
`default_nettype wire

// File: hdl/ptc_checker.sv
`default_nettype none
`include "pressure_temperature_compensation_macros.svh"
module ptc_checker import ptc_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic signed [15:0]    out_temperature_tenths,
  input wire logic signed [31:0]    out_pressure_pascal,
  input wire logic signed [15:0]    out_pressure_tens,
  input wire logic                  out_divide_error
);

  logic all_zero;
  assign all_zero = out_pressure_pascal == 32'sd0 && out_temperature_tenths == 16'sd0 &&
                    out_pressure_tens == 16'sd0;

  // a waiting result stays
  `PTC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // a waiting result keeps its pressure
  `PTC_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_pressure_pascal))
  // an error result carries zeros
  `PTC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_divide_error, all_zero)
  // a waiting result holds off new requests
  `PTC_ASSERT_IMP(a_in_hold, clk, rst_n, out_valid && out_stall, in_stall)
  // reset empties the pipe
  `PTC_ASSERT_RST(a_rst_empty, clk, !rst_n, !out_valid)

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
`default_nettype wire

// File: verif/pressure_temperature_compensation_tb.sv
`default_nettype none
module pressure_temperature_compensation_tb;
  import ptc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // block latency from request accept to result valid
  localparam int LATENCY = 79;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_raw_temperature;
  logic [18:0] in_raw_pressure;
  logic        out_valid;
  logic        out_stall;
  logic signed [15:0] out_temperature_tenths;
  logic signed [31:0] out_pressure_pascal;
  logic signed [15:0] out_pressure_tens;
  logic        out_divide_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pressure_temperature_compensation dut (.*);

  // one compensated reading
  typedef struct packed {
    logic [15:0] tenths;
    logic [31:0] pascal;
    logic [15:0] tens;
    logic        div_err;
  } reading_t;

  // one row of the directed table; has_exp marks rows with a typed-in answer
  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
    bit          has_exp;
    reading_t    exp;
  } stim_row_t;

  // calibration shadow kept by the testbench
  logic [1:0]  cal_oss;
  logic [47:0] cal_ac_s, cal_ac_u;
  logic [31:0] cal_b, cal_m;

  reading_t pending_readings[$];
  int errors = 0;
  int mismatches = 0;
  bit noisy = 1;  // random idling on both sides

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // overall limit: far above the slowest run, stalls included
  initial begin
    #20ms;
    $display("pressure_temperature_compensation_tb: done, errors");
    $finish;
  end

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    logic signed [31:0] s;
    s = v;
    return s >>> n;
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sdivide(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] sa, sb, qq;
    sa = $signed(a);
    sb = $signed(b);
    qq = sa / sb;
    return qq[31:0];
  endfunction

  // integer calibration formulas, 32-bit wrapping throughout
  function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
    reading_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, q, den;
    logic [31:0] t32;
    ac1 = sext(cal_ac_s[15:0]);
    ac2 = sext(cal_ac_s[31:16]);
    ac3 = sext(cal_ac_s[47:32]);
    ac4 = {16'd0, cal_ac_u[15:0]};
    ac5 = {16'd0, cal_ac_u[31:16]};
    ac6 = {16'd0, cal_ac_u[47:32]};
    b1 = sext(cal_b[15:0]);
    b2 = sext(cal_b[31:16]);
    mc = sext(cal_m[15:0]);
    md = sext(cal_m[31:16]);
    r = '0;
    r.div_err = 1'b1;
    x1 = asr(({16'd0, ut} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = sdivide(mc << 11, den);
    b5 = x1 + x2;
    b6 = b5 - 32'd4000;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 2);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = ({13'd0, up} - b3) * (32'd50000 >> cal_oss);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    q = asr(p, 8);
    x1 = q * q;
    x1 = asr(x1 * 32'd3038, 16);
    x2 = asr(C_M7357 * p, 16);
    p = p + asr(x1 + x2 + 32'd3791, 4);
    t32 = asr(b5 + 32'd8, 4);
    r.tenths = t32[15:0];
    r.pascal = p;
    t32 = sdivide(p, 32'd10);
    r.tens = t32[15:0];
    r.div_err = 1'b0;
    return r;
  endfunction

  task automatic cfg_write(input cfg_reg_t idx, input logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OVERSAMPLING: cal_oss = val[1:0];
      REG_COEF_AC_SIGNED: cal_ac_s = val;
      REG_COEF_AC_UNSIGNED: cal_ac_u = val;
      REG_COEF_B_PAIR: cal_b = val[31:0];
      REG_COEF_M_PAIR: cal_m = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // the block must be drained before any calibration change
  task automatic drain();
    int guard;
    guard = 0;
    while (pending_readings.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $display("pressure_temperature_compensation_tb: done, errors");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
    end
  endtask

  task automatic load_calibration(input logic [1:0] oss, input logic [47:0] acs,
                                  input logic [47:0] acu, input logic [31:0] b,
                                  input logic [31:0] m);
    drain();
    cfg_write(REG_OVERSAMPLING, {46'd0, oss});
    cfg_write(REG_COEF_AC_SIGNED, acs);
    cfg_write(REG_COEF_AC_UNSIGNED, acu);
    cfg_write(REG_COEF_B_PAIR, {16'd0, b});
    cfg_write(REG_COEF_M_PAIR, {16'd0, m});
  endtask

  // one request on the input channel, with a random gap before it;
  // valid stays high after the accept until the next falling edge decides
  task automatic send_reading(input logic [15:0] ut, input logic [18:0] up,
                              input bit typed, input reading_t typed_exp);
    @(negedge clk);
    while (noisy && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure <= up;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(typed ? typed_exp : compensate(ut, up));
  endtask

  // drop valid at the falling edge after the last request of a run
  task automatic end_requests();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // receiver: random stalls, compare with the oldest pending reading
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= noisy && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    reading_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_temperature_tenths, out_pressure_pascal, out_pressure_tens,
             out_divide_error};
      if (pending_readings.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result t=%0d p=%0d", out_temperature_tenths,
                   out_pressure_pascal);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: exp t=%0d p=%0d d=%0d e=%b  got t=%0d p=%0d d=%0d e=%b",
                     $signed(want.tenths), $signed(want.pascal), $signed(want.tens),
                     want.div_err, out_temperature_tenths, out_pressure_pascal,
                     out_pressure_tens, out_divide_error);
          mismatches++;
        end
      end
    end
  end

  // datasheet-like calibration, used for most of the run
  localparam logic [47:0] TYP_AC_S = {16'hC7D1, 16'hFB93, 16'd408};     // -14383, -1133
  localparam logic [47:0] TYP_AC_U = {16'd23153, 16'd32757, 16'd32741};
  localparam logic [31:0] TYP_B = {16'd4, 16'd6190};
  localparam logic [31:0] TYP_M = {16'd2868, 16'hD4BD};                 // mc -11075

  stim_row_t table_rows[$];

  function automatic stim_row_t row(input logic [15:0] ut, input logic [18:0] up,
                                    input bit typed, input reading_t e);
    stim_row_t r;
    r.ut = ut;
    r.up = up;
    r.has_exp = typed;
    r.exp = e;
    return r;
  endfunction

  task automatic run_table();
    foreach (table_rows[i]) begin
      send_reading(table_rows[i].ut, table_rows[i].up, table_rows[i].has_exp,
                   table_rows[i].exp);
    end
    end_requests();
    table_rows.delete();
  endtask

  task automatic random_burst(input int n, input bit wide);
    logic [15:0] ut;
    logic [18:0] up;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        ut = 16'($urandom);
        up = 19'($urandom);
      end else begin
        // realistic readings around room conditions
        ut = 16'($urandom_range(32000, 20000));
        up = 19'($urandom_range(50000, 15000) << cal_oss);
      end
      send_reading(ut, up, 1'b0, '0);
    end
    end_requests();
  endtask

  initial begin
    reading_t zero_err;
    zero_err = '0;
    zero_err.div_err = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OVERSAMPLING;
    cfg_data = '0;
    cal_oss = 2'd3;
    cal_ac_s = '0;
    cal_ac_u = '0;
    cal_b = '0;
    cal_m = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // after reset every coefficient is zero: x1 + md = 0, so a divide error
    table_rows.push_back(row(16'd0, 19'd0, 1, zero_err));
    table_rows.push_back(row(16'hFFFF, 19'h7FFFF, 1, zero_err));
    run_table();

    // typical calibration, extremes and mid values
    load_calibration(2'd0, TYP_AC_S, TYP_AC_U, TYP_B, TYP_M);
    table_rows.push_back(row(16'd27898, 19'd23843, 0, '0));
    table_rows.push_back(row(16'd0, 19'd0, 0, '0));
    table_rows.push_back(row(16'hFFFF, 19'h7FFFF, 0, '0));
    table_rows.push_back(row(16'h8000, 19'h40000, 0, '0));
    table_rows.push_back(row(16'h7FFF, 19'h3FFFF, 0, '0));
    table_rows.push_back(row(16'hAAAA, 19'h55555, 0, '0));
    table_rows.push_back(row(16'h5555, 19'h2AAAA, 0, '0));
    run_table();

    // zero pressure divisor: ac4 = 0 gives b4 = 0
    load_calibration(2'd1, TYP_AC_S, {TYP_AC_U[47:16], 16'd0}, TYP_B, TYP_M);
    table_rows.push_back(row(16'd27898, 19'd23843, 1, zero_err));
    table_rows.push_back(row(16'hFFFF, 19'd0, 1, zero_err));
    run_table();

    // zero temperature divisor: ac5 = 0 makes x1 = 0, md = 0
    load_calibration(2'd2, TYP_AC_S, {TYP_AC_U[47:32], 16'd0, TYP_AC_U[15:0]},
                     TYP_B, {16'd0, TYP_M[15:0]});
    table_rows.push_back(row(16'd12345, 19'd1000, 1, zero_err));
    run_table();

    // all-ones coefficients apart from the m pair, maximum oversampling: heavy wrapping
    load_calibration(2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                     32'h7FFF_8000);
    table_rows.push_back(row(16'd0, 19'd0, 0, '0));
    table_rows.push_back(row(16'hFFFF, 19'h7FFFF, 0, '0));
    table_rows.push_back(row(16'd30000, 19'd300000, 0, '0));
    run_table();

    // random part: several calibrations, each with typical and wide readings
    for (int phase = 0; phase < 8; phase++) begin
      logic [1:0] oss;
      oss = phase[1:0];
      if (phase < 4)
        load_calibration(oss, TYP_AC_S, TYP_AC_U, TYP_B, TYP_M);
      else
        load_calibration(oss, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         $urandom, $urandom);
      noisy = (phase != 2);  // one phase runs flat out on both sides
      random_burst(110, 1'b0);
      random_burst(50, 1'b1);
    end
    noisy = 1;

    drain();
    if (errors == 0) $display("pressure_temperature_compensation_tb: done, clean");
    else $display("pressure_temperature_compensation_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/ptc_pkg.sv
hdl/ptc_div_cell.sv
hdl/ptc_div_chain.sv
hdl/pressure_temperature_compensation.sv
hdl/ptc_checker.sv
verif/pressure_temperature_compensation_tb.sv
